// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of the project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk_sig, rstn_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (!(rstn_sig)) (prop)) else $error(msg);

// Concurrent assertion on the default clk and rst_n of the enclosing module.
`define ASSERT_DEF(lbl, prop, msg) `ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

// ----- design/fca_pkg.sv -----
// Package for the chain allocator: table size, entry marks, codes and request/result types.
// No dependencies.
package fca_pkg;

  // Table geometry and entry encoding.
  localparam int NUM_BLOCKS = 1024;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int VAL_W      = 11;
  localparam int CNT_W      = 11;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;

  localparam logic [VAL_W-1:0] END_MARK  = VAL_W'(NUM_BLOCKS);
  localparam logic [VAL_W-1:0] FREE_MARK = VAL_W'(NUM_BLOCKS + 1);

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  entry_index;
    logic [CNT_W-1:0]  block_count;
    logic [VAL_W-1:0]  entry_value;
  } fca_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    result_value;
    logic [CNT_W-1:0]    freed_count;
  } fca_res_t;

endpackage

// ----- design/fca_core.sv -----
// Sequencer and table memory of the chain allocator: clearing pass, allocate scan,
// chain walk, single-entry write and read. Depends on fca_pkg.
module fca_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  fca_pkg::fca_req_t req,
  output logic              res_valid,
  input  logic              res_ready,
  output fca_pkg::fca_res_t res
);
  import fca_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_RDW   = 4'd3;
  localparam logic [3:0] S_WRD   = 4'd4;
  localparam logic [3:0] S_WRW   = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_AEND  = 4'd7;
  localparam logic [3:0] S_FRD   = 4'd8;
  localparam logic [3:0] S_FWT   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);
  localparam logic [CNT_W-1:0] ALL_FREE = CNT_W'(NUM_BLOCKS);

  // Table memory: one write port, one registered read port.
  logic [VAL_W-1:0] mem [NUM_BLOCKS];
  logic [VAL_W-1:0] rdata_r;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic [VAL_W-1:0] wdata;
  logic             we;

  // Control state.
  logic [3:0]       state_r, state_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic [CNT_W-1:0] free_cnt_r, free_cnt_nxt;

  // Working registers of the current request.
  fca_req_t         req_r, req_nxt;
  fca_res_t         res_r, res_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [CNT_W-1:0] taken_r, taken_nxt;
  logic [IDX_W-1:0] first_r, first_nxt;
  logic [IDX_W-1:0] last_r, last_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0] freed_r, freed_nxt;

  // Memory array, written and read in one clocked block.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    free_cnt_nxt = free_cnt_r;
    req_nxt      = req_r;
    res_nxt      = res_r;
    scan_nxt     = scan_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    taken_nxt    = taken_r;
    first_nxt    = first_r;
    last_nxt     = last_r;
    cur_nxt      = cur_r;
    freed_nxt    = freed_r;
    raddr        = req_r.entry_index;
    waddr        = req_r.entry_index;
    wdata        = FREE_MARK;
    we           = 1'b0;
    res_valid    = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = FREE_MARK;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_valid) begin
          req_nxt = req;
          res_nxt = '{status: ST_OK, result_value: '0, freed_count: '0};
          unique case (req.mode)
            MODE_ALLOC: begin
              if (req.block_count == '0) begin
                res_nxt.status = ST_BAD;
                state_nxt      = S_DONE;
              end else if (req.block_count > free_cnt_r) begin
                res_nxt.status = ST_FULL;
                state_nxt      = S_DONE;
              end else begin
                scan_nxt   = '0;
                pend_v_nxt = 1'b0;
                taken_nxt  = '0;
                state_nxt  = S_SCAN;
              end
            end
            MODE_FREE: begin
              cur_nxt   = req.entry_index;
              freed_nxt = '0;
              state_nxt = S_FRD;
            end
            MODE_WRITE: begin
              if (req.entry_value > FREE_MARK) begin
                res_nxt.status = ST_BAD;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_WRD;
              end
            end
            default: begin
              state_nxt = S_RD;
            end
          endcase
        end
      end

      // Single-entry read: address out, then registered data back.
      S_RD: begin
        raddr     = req_r.entry_index;
        state_nxt = S_RDW;
      end
      S_RDW: begin
        res_nxt.result_value = rdata_r;
        state_nxt            = S_DONE;
      end

      // Single-entry write: fetch the old entry so the free count stays exact.
      S_WRD: begin
        raddr     = req_r.entry_index;
        state_nxt = S_WRW;
      end
      S_WRW: begin
        we    = 1'b1;
        waddr = req_r.entry_index;
        wdata = req_r.entry_value;
        if ((rdata_r == FREE_MARK) && (req_r.entry_value != FREE_MARK)) begin
          free_cnt_nxt = free_cnt_r - 1'b1;
        end else if ((rdata_r != FREE_MARK) && (req_r.entry_value == FREE_MARK)) begin
          free_cnt_nxt = free_cnt_r + 1'b1;
        end
        state_nxt = S_DONE;
      end

      // Allocate scan: one read issued per cycle, the previous read checked.
      // Each free entry found links the previous chain entry to it.
      S_SCAN: begin
        raddr        = scan_r;
        scan_nxt     = scan_r + 1'b1;
        pend_v_nxt   = 1'b1;
        pend_idx_nxt = scan_r;
        if (pend_v_r && (rdata_r == FREE_MARK)) begin
          if (taken_r == '0) begin
            first_nxt = pend_idx_r;
          end else begin
            we    = 1'b1;
            waddr = last_r;
            wdata = VAL_W'(pend_idx_r);
          end
          last_nxt  = pend_idx_r;
          taken_nxt = taken_r + 1'b1;
          if (taken_nxt == req_r.block_count) begin
            state_nxt = S_AEND;
          end
        end
      end
      S_AEND: begin
        we                   = 1'b1;
        waddr                = last_r;
        wdata                = END_MARK;
        free_cnt_nxt         = free_cnt_r - req_r.block_count;
        res_nxt.result_value = VAL_W'(first_r);
        state_nxt            = S_DONE;
      end

      // Chain walk: read an entry, free it, follow its link.
      S_FRD: begin
        raddr     = cur_r;
        state_nxt = S_FWT;
      end
      S_FWT: begin
        if (rdata_r == FREE_MARK) begin
          res_nxt.freed_count = freed_r;
          state_nxt           = S_DONE;
        end else begin
          we           = 1'b1;
          waddr        = cur_r;
          wdata        = FREE_MARK;
          freed_nxt    = freed_r + 1'b1;
          free_cnt_nxt = free_cnt_r + 1'b1;
          if (rdata_r == END_MARK) begin
            res_nxt.freed_count = freed_nxt;
            state_nxt           = S_DONE;
          end else begin
            cur_nxt   = rdata_r[IDX_W-1:0];
            state_nxt = S_FRD;
          end
        end
      end

      // Hold the result until the output register takes it.
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      free_cnt_r <= ALL_FREE;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      free_cnt_r <= free_cnt_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    scan_r     <= scan_nxt;
    pend_v_r   <= pend_v_nxt;
    pend_idx_r <= pend_idx_nxt;
    taken_r    <= taken_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    cur_r      <= cur_nxt;
    freed_r    <= freed_nxt;
  end

  assign req_ready = (state_r == S_IDLE);
  assign res       = res_r;

endmodule

// ----- design/fat_chain_allocator.sv -----
// Top level of the chain allocator: request handshake and output result register.
// Depends on fca_pkg and fca_core.
//
// A file allocation table of 1024 entries, each a next-block link, an end mark
// or a free mark, served one request at a time by a single sequencer around
// one table memory. After reset a clearing pass writes the free mark to every
// entry, during which no request is accepted. A read or a write sets up the
// address, then uses the registered data. Allocate scans upward from entry 0
// with one memory read per cycle and writes the end mark after the last block
// claimed; a rejected allocate goes straight to its result. Free walks the
// chain one entry at a time, as each link is known only once the entry before
// it has been read. A finished result waits in the output register, and the
// next request is accepted while it does.
module fat_chain_allocator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fca_pkg::fca_req_t in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output fca_pkg::fca_res_t out_res
);
  import fca_pkg::*;

  logic     core_ready;
  logic     res_valid;
  logic     res_ready;
  fca_res_t core_res;
  logic     out_valid_r, out_valid_nxt;
  fca_res_t out_res_r;

  fca_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_ready (core_ready),
    .req       (in_req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (core_res)
  );

  // Input side stalls whenever the sequencer is busy.
  assign in_stall = !core_ready;

  // Output register: loads when empty or being drained this cycle.
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ----- design/fca_checker.sv -----
// Port-level checker for the chain allocator and its bind to the top level.
// Depends on fca_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fca_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input fca_pkg::fca_req_t in_req,
  input logic              out_valid,
  input logic              out_stall,
  input fca_pkg::fca_res_t out_res
);
  import fca_pkg::*;

  // A stalled result holds its value.
  `ASSERT_DEF(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_res)), "stalled result changed")

  // One request at a time: an accepted request makes the block busy next cycle.
  `ASSERT_DEF(a_one_inflight, (in_valid && !in_stall) |=> in_stall, "request accepted while busy")

  // Only defined status codes appear.
  `ASSERT_DEF(a_status_code, out_valid |-> ((out_res.status == ST_OK) || (out_res.status == ST_FULL) || (out_res.status == ST_BAD)), "undefined status code")

  // A failed request reports no value and no freed entries.
  `ASSERT_DEF(a_fail_zero, (out_valid && (out_res.status != ST_OK)) |-> ((out_res.result_value == '0) && (out_res.freed_count == '0)), "failed request carries data")

  // Freed entries are only reported by a free request, which returns no value.
  `ASSERT_DEF(a_freed_novalue, (out_valid && (out_res.freed_count != '0)) |-> (out_res.result_value == '0), "freed count with a value")

endmodule

bind fat_chain_allocator fca_checker u_fca_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_res   (out_res)
);

// ----- verif/tb.sv -----
// Self-checking testbench for fat_chain_allocator: directed and random allocate, free,
// write and read requests checked against a shadow of the allocation table.
// Depends on fca_pkg and the fat_chain_allocator RTL.
module tb;
  import fca_pkg::*;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  fca_req_t in_req    = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  fca_res_t out_res;

  // Shadow of the allocation table, cleared to free as the block is after reset.
  logic [VAL_W-1:0] fat_shadow [NUM_BLOCKS];
  fca_res_t         outcome_q [$];
  int unsigned      chain_heads [$];
  fca_res_t         last_outcome;
  int unsigned      fail_count    = 0;
  bit               send_gaps_on  = 1'b1;
  bit               stall_on      = 1'b1;
  int unsigned      stall_left    = 0;

  fat_chain_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  always #5 clk = ~clk;

  initial begin
    foreach (fat_shadow[i]) fat_shadow[i] = FREE_MARK;
  end

  // Number of entries currently holding the free mark.
  function automatic int unsigned free_entries();
    int unsigned n;
    n = 0;
    foreach (fat_shadow[i]) begin
      if (fat_shadow[i] == FREE_MARK) n++;
    end
    return n;
  endfunction

  // Applies one request to the shadow table and returns the result it must produce.
  function automatic fca_res_t fat_outcome(input fca_req_t req);
    fca_res_t         res;
    int unsigned      taken;
    int unsigned      idx;
    int unsigned      prev;
    int unsigned      walk;
    logic [VAL_W-1:0] link;
    res = '0;
    case (req.mode)
      MODE_ALLOC: begin
        // A zero count is rejected, and a count beyond the free entries changes nothing.
        if (req.block_count == '0) begin
          res.status = ST_BAD;
        end else if (req.block_count > free_entries()) begin
          res.status = ST_FULL;
        end else begin
          taken = 0;
          prev  = 0;
          for (idx = 0; idx < NUM_BLOCKS && taken < req.block_count; idx++) begin
            if (fat_shadow[idx] == FREE_MARK) begin
              fat_shadow[idx] = END_MARK;
              if (taken == 0) res.result_value = VAL_W'(idx);
              else fat_shadow[prev] = VAL_W'(idx);
              prev = idx;
              taken++;
            end
          end
          res.status = ST_OK;
        end
      end
      MODE_FREE: begin
        // The walk ends at an end mark or at an entry that is already free,
        // which also ends a chain that loops back on itself.
        walk = req.entry_index;
        while (walk < NUM_BLOCKS) begin
          link = fat_shadow[walk];
          if (link == FREE_MARK) break;
          fat_shadow[walk] = FREE_MARK;
          res.freed_count = res.freed_count + 1'b1;
          if (link == END_MARK) break;
          walk = link;
        end
        res.status = ST_OK;
      end
      MODE_WRITE: begin
        if (req.entry_value > FREE_MARK) begin
          res.status = ST_BAD;
        end else begin
          fat_shadow[req.entry_index] = req.entry_value;
          res.status = ST_OK;
        end
      end
      default: begin
        res.status       = ST_OK;
        res.result_value = fat_shadow[req.entry_index];
      end
    endcase
    return res;
  endfunction

  function automatic fca_req_t make_req(input logic [MODE_W-1:0] mode, input int unsigned idx,
                                        input int unsigned cnt, input int unsigned val);
    fca_req_t req;
    req.mode        = mode;
    req.entry_index = IDX_W'(idx);
    req.block_count = CNT_W'(cnt);
    req.entry_value = VAL_W'(val);
    return req;
  endfunction

  // Presents one request after a random gap, waits for it to be taken and
  // records the result it must produce.
  task automatic send_req(input fca_req_t req);
    int unsigned gap;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!send_gaps_on || roll < 50) gap = 0;
    else if (roll < 85) gap = $urandom_range(1, 3);
    else if (roll < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    last_outcome = fat_outcome(req);
    outcome_q.push_back(last_outcome);
    if (req.mode == MODE_ALLOC && last_outcome.status == ST_OK) begin
      chain_heads.push_back(last_outcome.result_value);
    end
  endtask

  // Random request, mostly allocations and frees of live chains, with some
  // writes that splice or break chains and some reads.
  function automatic fca_req_t random_request();
    fca_req_t    req;
    int unsigned roll;
    int unsigned sub;
    int unsigned pick;
    int unsigned i;
    req.mode        = MODE_READ;
    req.entry_index = IDX_W'($urandom);
    req.block_count = CNT_W'($urandom);
    req.entry_value = VAL_W'($urandom);
    roll = $urandom_range(0, 99);
    sub  = $urandom_range(0, 99);
    if (free_entries() < 200) begin
      // Keep the table from filling up: release a chain or the lowest used entry.
      req.mode = MODE_FREE;
      if (chain_heads.size() != 0) begin
        req.entry_index = IDX_W'(chain_heads.pop_front());
      end else begin
        for (i = NUM_BLOCKS; i > 0; i--) begin
          if (fat_shadow[i-1] != FREE_MARK) req.entry_index = IDX_W'(i - 1);
        end
      end
    end else if (roll < 35) begin
      req.mode = MODE_ALLOC;
      if (sub < 4) req.block_count = '0;
      else if (sub < 9) req.block_count = CNT_W'($urandom);
      else if (sub < 84) req.block_count = CNT_W'($urandom_range(1, 8));
      else req.block_count = CNT_W'($urandom_range(9, 64));
    end else if (roll < 60) begin
      req.mode = MODE_FREE;
      if (sub < 80 && chain_heads.size() != 0) begin
        pick            = $urandom_range(0, chain_heads.size() - 1);
        req.entry_index = IDX_W'(chain_heads[pick]);
        chain_heads.delete(pick);
      end else if (sub < 90) begin
        req.entry_index = IDX_W'($urandom_range(0, 127));
      end
    end else if (roll < 80) begin
      req.mode = MODE_WRITE;
      if ($urandom_range(0, 99) < 80) req.entry_index = IDX_W'($urandom_range(0, 127));
      if (sub < 40) req.entry_value = VAL_W'($urandom_range(0, 127));
      else if (sub < 60) req.entry_value = END_MARK;
      else if (sub < 80) req.entry_value = FREE_MARK;
      else if (sub < 90) req.entry_value = VAL_W'($urandom_range(0, NUM_BLOCKS - 1));
      else req.entry_value = VAL_W'($urandom_range(NUM_BLOCKS + 2, 2047));
    end else begin
      if (sub < 70) req.entry_index = IDX_W'($urandom_range(0, 127));
    end
    return req;
  endfunction

  // Receiver stall: mostly short, now and then long.
  always @(posedge clk) begin : recv_stall
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!stall_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (roll < 60) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b1;
      if (roll < 90) stall_left <= $urandom_range(0, 2);
      else if (roll < 98) stall_left <= $urandom_range(3, 11);
      else stall_left <= $urandom_range(29, 79);
    end
  end

  // Each delivered result is compared with the oldest pending outcome.
  always @(posedge clk) begin : result_check
    fca_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (outcome_q.size() == 0) begin
        $error("result delivered with no request pending");
        fail_count++;
      end else begin
        want = outcome_q.pop_front();
        if (out_res.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_res.status);
          fail_count++;
        end
        if (out_res.result_value !== want.result_value) begin
          $error("result_value: expected %0d, got %0d", want.result_value,
                 out_res.result_value);
          fail_count++;
        end
        if (out_res.freed_count !== want.freed_count) begin
          $error("freed_count: expected %0d, got %0d", want.freed_count,
                 out_res.freed_count);
          fail_count++;
        end
      end
    end
  end

  // Field extremes, every mode and the corner cases of allocate and free.
  task automatic test_directed();
    // A fresh table reads free everywhere.
    send_req(make_req(MODE_READ, 0, 0, 0));
    send_req(make_req(MODE_READ, 1023, 2047, 2047));
    // Zero count and a count larger than the table are both refused.
    send_req(make_req(MODE_ALLOC, 0, 0, 0));
    send_req(make_req(MODE_ALLOC, 1023, 2047, 2047));
    // Take the whole table, fail to take one more, then release it all.
    send_req(make_req(MODE_ALLOC, 0, NUM_BLOCKS, 0));
    send_req(make_req(MODE_ALLOC, 0, 1, 0));
    send_req(make_req(MODE_FREE, 0, 0, 0));
    // A short chain and its links.
    send_req(make_req(MODE_ALLOC, 0, 3, 0));
    send_req(make_req(MODE_READ, 0, 0, 0));
    send_req(make_req(MODE_READ, 2, 0, 0));
    // Values above the free mark are not written.
    send_req(make_req(MODE_WRITE, 1023, 0, 2047));
    send_req(make_req(MODE_WRITE, 1023, 0, NUM_BLOCKS + 2));
    // Splice the top entry in front of the chain and free the whole thing.
    send_req(make_req(MODE_WRITE, 1023, 0, 0));
    send_req(make_req(MODE_FREE, 1023, 0, 0));
    // An entry that links to itself.
    send_req(make_req(MODE_WRITE, 700, 0, 700));
    send_req(make_req(MODE_FREE, 700, 0, 0));
    // A three-entry loop entered from the middle.
    send_req(make_req(MODE_WRITE, 10, 0, 11));
    send_req(make_req(MODE_WRITE, 11, 0, 12));
    send_req(make_req(MODE_WRITE, 12, 0, 10));
    send_req(make_req(MODE_FREE, 11, 0, 0));
    // Freeing an entry that is already free.
    send_req(make_req(MODE_FREE, 500, 0, 0));
    // End and free marks written and read back.
    send_req(make_req(MODE_WRITE, 5, 0, END_MARK));
    send_req(make_req(MODE_READ, 5, 0, 0));
    send_req(make_req(MODE_WRITE, 5, 0, FREE_MARK));
    send_req(make_req(MODE_READ, 5, 0, 0));
  endtask

  // Fill the table with large chains until it refuses, take the exact
  // remainder, then release everything.
  task automatic test_fill_drain();
    int unsigned i;
    int unsigned used;
    do begin
      send_req(make_req(MODE_ALLOC, $urandom, $urandom_range(60, 200), $urandom));
    end while (last_outcome.status != ST_FULL);
    if (free_entries() != 0) send_req(make_req(MODE_ALLOC, $urandom, free_entries(), 0));
    send_req(make_req(MODE_ALLOC, $urandom, 1, $urandom));
    while (chain_heads.size() != 0) begin
      send_req(make_req(MODE_FREE, chain_heads.pop_front(), $urandom, $urandom));
    end
    while (free_entries() != NUM_BLOCKS) begin
      used = 0;
      for (i = NUM_BLOCKS; i > 0; i--) begin
        if (fat_shadow[i-1] != FREE_MARK) used = i - 1;
      end
      send_req(make_req(MODE_FREE, used, $urandom, $urandom));
    end
  endtask

  // Random request mix with idling on both sides.
  task automatic test_random_mix();
    repeat (430) send_req(random_request());
  endtask

  // Requests back to back, first with no receiver stall, then with it.
  task automatic test_back_to_back();
    send_gaps_on = 1'b0;
    stall_on    <= 1'b0;
    repeat (50) send_req(random_request());
    stall_on    <= 1'b1;
    repeat (50) send_req(random_request());
    send_gaps_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_fill_drain();
    test_random_mix();
    test_back_to_back();
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (2100) @(posedge clk);
    if (fail_count == 0) begin
      $display("fat_chain_allocator verification clean");
    end else begin
      $display("fat_chain_allocator verification failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #60000000;
    $display("fat_chain_allocator verification failed");
    $finish;
  end

endmodule
